// ===== src/psdt_pkg.sv =====
// ----------------------------------------------------------------------------
// psdt_pkg
// Shared codes, widths, request/response types and helpers for the
// per-state dominance table.
// ----------------------------------------------------------------------------
package psdt_pkg;

	localparam logic [1:0] MODE_CHECK  = 2'd0;
	localparam logic [1:0] MODE_EXPAND = 2'd1;
	localparam logic [1:0] MODE_ROUND  = 2'd2;

	localparam logic [2:0] ORD_LEX1   = 3'd0;
	localparam logic [2:0] ORD_LEX2   = 3'd1;
	localparam logic [2:0] ORD_SCORE  = 3'd2;
	localparam logic [2:0] ORD_SKEW   = 3'd3;
	localparam logic [2:0] ORD_PARETO = 3'd4;

	localparam logic [1:0] REG_ORDER   = 2'd0;
	localparam logic [1:0] REG_BUDGET1 = 2'd1;
	localparam logic [1:0] REG_BUDGET2 = 2'd2;

	localparam logic [31:0] ONES32 = 32'hFFFF_FFFF;

	localparam int DIV_NW = 65;
	localparam int DIV_DW = 34;

	typedef struct packed {
		logic [32:0] sum_first;
		logic [32:0] sum_second;
		logic [31:0] bud_first;
		logic [31:0] bud_second;
		logic        skew;
	} score_req_t;

	typedef struct packed {
		logic        done;
		logic        ok;
		logic [31:0] score;
	} score_rsp_t;

	function automatic logic [31:0] sat32(input logic [DIV_NW-1:0] v);
		sat32 = (|v[DIV_NW-1:32]) ? ONES32 : v[31:0];
	endfunction

endpackage

// ===== src/psdt_ram.sv =====
// ----------------------------------------------------------------------------
// psdt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module psdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                  wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/psdt_div.sv =====
// ----------------------------------------------------------------------------
// psdt_div
// Restoring divider, one quotient bit per cycle, 65-bit dividend.
// ----------------------------------------------------------------------------
module psdt_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [psdt_pkg::DIV_NW-1:0]   dividend,
	input  logic [psdt_pkg::DIV_DW-1:0]   divisor,
	output logic                          done,
	output logic [psdt_pkg::DIV_NW-1:0]   quotient
);

	localparam int NW = psdt_pkg::DIV_NW;
	localparam int DW = psdt_pkg::DIV_DW;

	logic          busy_q;
	logic          done_q;
	logic [6:0]    cnt_q;
	logic [NW-1:0] num_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   trial;
	logic          ge;

	assign trial = {rem_q, num_q[NW-1]};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			if (ge) begin
				rem_q <= DW'(trial - {1'b0, den_q});
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/psdt_score.sv =====
// ----------------------------------------------------------------------------
// psdt_score
// Fixed-point path score sequencer: one shared divider, one shared
// 32x32 multiplier, plain or skewed budget scaling.
// ----------------------------------------------------------------------------
module psdt_score #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  psdt_pkg::score_req_t   req,
	output psdt_pkg::score_rsp_t   rsp
);

	localparam int NW = psdt_pkg::DIV_NW;
	localparam int DW = psdt_pkg::DIV_DW;

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_WF1  = 14'b00000000000010,
		S_WF2  = 14'b00000000000100,
		S_M1   = 14'b00000000001000,
		S_L1   = 14'b00000000010000,
		S_W1   = 14'b00000000100000,
		S_M2   = 14'b00000001000000,
		S_L2   = 14'b00000010000000,
		S_W2   = 14'b00000100000000,
		S_SQ1  = 14'b00001000000000,
		S_SQ2  = 14'b00010000000000,
		S_SQ3  = 14'b00100000000000,
		S_LS   = 14'b01000000000000,
		S_WS   = 14'b10000000000000
	} sc_state_t;

	sc_state_t     state_q;
	logic [31:0]   f1_q;
	logic [31:0]   f2_q;
	logic [63:0]   prod_q;
	logic [NW-1:0] acc_q;
	logic          done_q;
	logic          ok_q;
	logic [31:0]   score_q;

	logic          div_start;
	logic          div_done;
	logic [NW-1:0] div_num;
	logic [DW-1:0] div_den;
	logic [NW-1:0] div_quo;
	logic [31:0]   mul_a;
	logic [31:0]   mul_b;
	logic [32:0]   fsum;
	logic [DW-1:0] tot;

	assign fsum = 33'(f1_q) + 33'(f2_q);
	assign tot = DW'(req.bud_first) + DW'(req.bud_second);

	always_comb begin
		div_start = 1'b0;
		div_num = NW'(req.sum_first) << FRAC_BITS;
		div_den = DW'(req.bud_first);
		mul_a = f1_q;
		mul_b = req.bud_second;
		case (state_q)
			S_IDLE: begin
				div_start = start;
			end
			S_WF1: begin
				div_start = div_done;
				div_num = NW'(req.sum_second) << FRAC_BITS;
				div_den = DW'(req.bud_second);
			end
			S_L1, S_L2: begin
				div_start = 1'b1;
				div_num = NW'(prod_q);
				div_den = tot;
			end
			S_LS: begin
				div_start = 1'b1;
				div_num = acc_q;
				div_den = DW'(fsum);
			end
			S_M2: begin
				mul_a = f2_q;
				mul_b = req.bud_first;
			end
			S_SQ1: begin
				mul_b = f1_q;
			end
			S_SQ2: begin
				mul_a = f2_q;
				mul_b = f2_q;
			end
			default: begin
			end
		endcase
	end

	psdt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: if (start) state_q <= S_WF1;
				S_WF1:  if (div_done) state_q <= S_WF2;
				S_WF2: begin
					if (div_done) state_q <= req.skew ? S_M1 : S_SQ1;
				end
				S_M1:  state_q <= S_L1;
				S_L1:  state_q <= S_W1;
				S_W1:  if (div_done) state_q <= S_M2;
				S_M2:  state_q <= S_L2;
				S_L2:  state_q <= S_W2;
				S_W2:  if (div_done) state_q <= S_SQ1;
				S_SQ1: begin
					if (fsum == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SQ2;
					end
				end
				S_SQ2: state_q <= S_SQ3;
				S_SQ3: state_q <= S_LS;
				S_LS:  state_q <= S_WS;
				S_WS: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_WF1: if (div_done) f1_q <= psdt_pkg::sat32(div_quo);
			S_WF2: if (div_done) f2_q <= psdt_pkg::sat32(div_quo);
			S_W1:  if (div_done) f1_q <= div_quo[31:0];
			S_W2:  if (div_done) f2_q <= div_quo[31:0];
			S_M1, S_M2, S_SQ1: prod_q <= mul_a * mul_b;
			S_SQ2: begin
				acc_q  <= NW'(prod_q);
				prod_q <= mul_a * mul_b;
			end
			S_SQ3: acc_q <= acc_q + NW'(prod_q);
			default: begin
			end
		endcase
		if (state_q == S_SQ1 && fsum == '0) begin
			ok_q <= 1'b0;
		end else if (state_q == S_WS && div_done) begin
			ok_q    <= 1'b1;
			score_q <= psdt_pkg::sat32(div_quo);
		end
	end

	assign rsp.done = done_q;
	assign rsp.ok = ok_q;
	assign rsp.score = score_q;

endmodule

// ===== src/per_state_dominance_table.sv =====
// ----------------------------------------------------------------------------
// per_state_dominance_table
// Per-state dominance records with lazy round reset: lexicographic,
// budget-score and Pareto-front rules over a record RAM and a front RAM.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  in       | in_valid / in_stall    | mode, state_index, costs, heuristics
//  out      | out_valid / out_stall  | dominated
//  cfg      | APB write/read         | order_mode, budget_first, budget_second
//
// After reset a clearing pass writes every record, with no item taken.
// Score rules use the serial divider: up to 3 divisions, or up to 5 with
// skewed scaling. Pareto rules scan a front of n points, one front RAM read
// per cycle. The result register lets the next transfer start while a
// result waits on out_stall.
// ----------------------------------------------------------------------------
module per_state_dominance_table #(
	parameter int NUM_STATES  = 1024,
	parameter int FRONT_DEPTH = 64,
	parameter int FRAC_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [9:0]  state_index,
	input  logic [31:0] cost_first,
	input  logic [31:0] cost_second,
	input  logic [31:0] heur_first,
	input  logic [31:0] heur_second,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        dominated,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(NUM_STATES > 1 ? NUM_STATES : 2);
	localparam int SW = FRONT_DEPTH > 1 ? $clog2(FRONT_DEPTH) : 1;
	localparam int CW = $clog2(FRONT_DEPTH + 1);
	localparam int RW = 128 + CW;
	localparam int FRONT_WORDS = NUM_STATES * (2 ** SW);

	typedef enum logic [8:0] {
		ST_CLR   = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_RD    = 9'b000000100,
		ST_EVAL  = 9'b000001000,
		ST_SCORE = 9'b000010000,
		ST_FCHK  = 9'b000100000,
		ST_FCMP  = 9'b001000000,
		ST_FEND  = 9'b010000000,
		ST_FIN   = 9'b100000000
	} state_t;

	state_t      state_q;
	logic [2:0]  order_q;
	logic [31:0] bud1_q;
	logic [31:0] bud2_q;
	logic [31:0] round_q;
	logic [AW-1:0] clr_q;
	logic        exp_q;
	logic [AW-1:0] idx_q;
	logic [31:0] g1_q, g2_q, h1_q, h2_q;
	logic [31:0] stamp_q, best2_q, best1_q, bscore_q;
	logic [CW-1:0] cnt_q, n_q, rd_i_q, w_q;
	logic        pv_q, found_q, res_q;
	logic        out_valid_q, dom_q;

	logic        in_fire, cfg_we, idx_ok, cur;
	logic [31:0] eff2, eff1, effs;
	logic [CW-1:0] effcnt, cnt_lim, new_cnt;
	logic        dom_l1, dom_l2, sdom;
	logic [31:0] news;
	logic        rec_we;
	logic [AW-1:0] rec_waddr;
	logic [RW-1:0] rec_wdata, rec_rdata;
	logic        front_we;
	logic [CW-1:0] front_slot;
	logic [63:0] front_wdata, front_rdata;
	logic [31:0] p1, p2;
	logic        p_dom, p_keep, scan_end;
	logic        sc_start;
	psdt_pkg::score_req_t sc_req;
	psdt_pkg::score_rsp_t sc_rsp;

	assign in_fire = in_valid && !in_stall;
	assign in_stall = state_q != ST_IDLE;
	assign cfg_we = psel && penable && pwrite;
	assign pready = 1'b1;
	assign idx_ok = 32'(state_index) < 32'(NUM_STATES);

	assign cur = (round_q != '0) && (stamp_q == round_q);
	assign eff2 = cur ? best2_q : psdt_pkg::ONES32;
	assign eff1 = cur ? best1_q : psdt_pkg::ONES32;
	assign effs = cur ? bscore_q : psdt_pkg::ONES32;
	assign effcnt = cur ? cnt_q : '0;
	assign cnt_lim = (cnt_q > CW'(FRONT_DEPTH)) ? CW'(FRONT_DEPTH) : cnt_q;
	assign new_cnt = (w_q < CW'(FRONT_DEPTH)) ? w_q + CW'(1) : w_q;
	assign dom_l1 = cur && (g2_q >= best2_q);
	assign dom_l2 = cur && (g1_q >= best1_q);
	assign sdom = sc_rsp.ok && cur && (sc_rsp.score >= bscore_q);
	assign news = (sc_rsp.ok && sc_rsp.score < effs) ? sc_rsp.score : effs;

	assign p1 = front_rdata[31:0];
	assign p2 = front_rdata[63:32];
	assign p_dom = (p1 <= g1_q) && (p2 <= g2_q);
	assign p_keep = !((p1 >= g1_q) && (p2 >= g2_q));
	assign scan_end = (rd_i_q == n_q) && !pv_q;

	always_comb begin
		case (paddr[3:2])
			psdt_pkg::REG_ORDER:   prdata = 32'(order_q);
			psdt_pkg::REG_BUDGET1: prdata = bud1_q;
			psdt_pkg::REG_BUDGET2: prdata = bud2_q;
			default:               prdata = '0;
		endcase
	end

	assign sc_req.sum_first = 33'(g1_q) + 33'(h1_q);
	assign sc_req.sum_second = 33'(g2_q) + 33'(h2_q);
	assign sc_req.bud_first = (bud1_q == '0) ? 32'd1 : bud1_q;
	assign sc_req.bud_second = (bud2_q == '0) ? 32'd1 : bud2_q;
	assign sc_req.skew = order_q == psdt_pkg::ORD_SKEW;

	always_comb begin
		rec_we = 1'b0;
		rec_waddr = idx_q;
		rec_wdata = {round_q, eff2, eff1, effs, effcnt};
		front_we = 1'b0;
		front_slot = w_q;
		front_wdata = {g2_q, g1_q};
		sc_start = 1'b0;
		case (state_q)
			ST_CLR: begin
				rec_we = 1'b1;
				rec_waddr = clr_q;
				rec_wdata = '0;
			end
			ST_EVAL: begin
				case (order_q) inside
					psdt_pkg::ORD_LEX1: begin
						rec_we = exp_q && !dom_l1;
						rec_wdata = {round_q, (g2_q < eff2) ? g2_q : eff2, eff1, effs, effcnt};
					end
					psdt_pkg::ORD_LEX2: begin
						rec_we = exp_q && !dom_l2;
						rec_wdata = {round_q, eff2, (g1_q < eff1) ? g1_q : eff1, effs, effcnt};
					end
					[psdt_pkg::ORD_SCORE:psdt_pkg::ORD_SKEW]: begin
						sc_start = cur || exp_q;
					end
					default: begin
						rec_we = exp_q && !cur;
						rec_wdata = {round_q, eff2, eff1, effs, CW'(1)};
						front_we = exp_q && !cur;
						front_slot = '0;
					end
				endcase
			end
			ST_SCORE: begin
				rec_we = sc_rsp.done && exp_q && !sdom;
				rec_wdata = {round_q, eff2, eff1, news, effcnt};
			end
			ST_FCMP: begin
				front_we = pv_q && p_keep;
				front_wdata = front_rdata;
			end
			ST_FEND: begin
				rec_we = 1'b1;
				rec_wdata = {round_q, eff2, eff1, effs, new_cnt};
				front_we = w_q < CW'(FRONT_DEPTH);
			end
			default: begin
			end
		endcase
	end

	psdt_ram #(.WIDTH(RW), .DEPTH(NUM_STATES)) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (rec_wdata),
		.raddr (AW'(state_index)),
		.rdata (rec_rdata)
	);

	psdt_ram #(.WIDTH(64), .DEPTH(FRONT_WORDS)) u_front_ram (
		.clk   (clk),
		.we    (front_we),
		.waddr ({idx_q, front_slot[SW-1:0]}),
		.wdata (front_wdata),
		.raddr ({idx_q, rd_i_q[SW-1:0]}),
		.rdata (front_rdata)
	);

	psdt_score #(.FRAC_BITS(FRAC_BITS)) u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sc_start),
		.req    (sc_req),
		.rsp    (sc_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= psdt_pkg::ORD_LEX1;
			bud1_q  <= 32'd1;
			bud2_q  <= 32'd1;
		end else if (cfg_we) begin
			case (paddr[3:2])
				psdt_pkg::REG_ORDER:   order_q <= pwdata[2:0];
				psdt_pkg::REG_BUDGET1: bud1_q <= pwdata;
				psdt_pkg::REG_BUDGET2: bud2_q <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			round_q     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			pv_q        <= 1'b0;
		end else begin
			if (state_q == ST_FIN && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NUM_STATES - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_fire) begin
						if (mode == psdt_pkg::MODE_ROUND) begin
							round_q <= (round_q == psdt_pkg::ONES32) ? 32'd1 : round_q + 32'd1;
							state_q <= ST_FIN;
						end else if (!idx_ok) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: state_q <= ST_EVAL;
				ST_EVAL: begin
					case (order_q) inside
						psdt_pkg::ORD_LEX1, psdt_pkg::ORD_LEX2: state_q <= ST_FIN;
						[psdt_pkg::ORD_SCORE:psdt_pkg::ORD_SKEW]: begin
							state_q <= (cur || exp_q) ? ST_SCORE : ST_FIN;
						end
						default: begin
							state_q <= cur ? ST_FCHK : ST_FIN;
							pv_q <= 1'b0;
						end
					endcase
				end
				ST_SCORE: if (sc_rsp.done) state_q <= ST_FIN;
				ST_FCHK, ST_FCMP: begin
					pv_q <= rd_i_q < n_q;
					if (scan_end) begin
						if (state_q == ST_FCMP) begin
							state_q <= ST_FEND;
						end else if (found_q || !exp_q) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_FCMP;
						end
					end
				end
				ST_FEND: state_q <= ST_FIN;
				ST_FIN: if (!out_valid_q || !out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				exp_q <= mode == psdt_pkg::MODE_EXPAND;
				idx_q <= AW'(state_index);
				g1_q  <= cost_first;
				g2_q  <= cost_second;
				h1_q  <= heur_first;
				h2_q  <= heur_second;
				res_q <= 1'b0;
			end
			ST_RD: begin
				stamp_q  <= rec_rdata[RW-1 -: 32];
				best2_q  <= rec_rdata[RW-33 -: 32];
				best1_q  <= rec_rdata[RW-65 -: 32];
				bscore_q <= rec_rdata[RW-97 -: 32];
				cnt_q    <= rec_rdata[CW-1:0];
			end
			ST_EVAL: begin
				case (order_q) inside
					psdt_pkg::ORD_LEX1: res_q <= dom_l1;
					psdt_pkg::ORD_LEX2: res_q <= dom_l2;
					[psdt_pkg::ORD_SCORE:psdt_pkg::ORD_SKEW]: res_q <= 1'b0;
					default: begin
						res_q   <= 1'b0;
						n_q     <= cnt_lim;
						rd_i_q  <= '0;
						found_q <= 1'b0;
					end
				endcase
			end
			ST_SCORE: if (sc_rsp.done) res_q <= sdom;
			ST_FCHK: begin
				if (rd_i_q < n_q) rd_i_q <= rd_i_q + CW'(1);
				if (pv_q && p_dom) found_q <= 1'b1;
				if (scan_end) begin
					res_q  <= found_q;
					rd_i_q <= '0;
					w_q    <= '0;
				end
			end
			ST_FCMP: begin
				if (rd_i_q < n_q) rd_i_q <= rd_i_q + CW'(1);
				if (pv_q && p_keep) w_q <= w_q + CW'(1);
			end
			ST_FIN: if (!out_valid_q || !out_stall) dom_q <= res_q;
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign dominated = dom_q;

endmodule

// ===== src/psdt_checker.sv =====
// ----------------------------------------------------------------------------
// psdt_checker
// Port-level checks of the dominance table, bound to the top level.
// ----------------------------------------------------------------------------
module psdt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] mode,
	input logic       out_valid,
	input logic       out_stall,
	input logic       dominated
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(dominated))
		else $error("result changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transfer taken while busy");

	a_round_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == psdt_pkg::MODE_ROUND && !out_valid
		|-> ##2 (out_valid && !dominated))
		else $error("new-round request gave no clear result");

endmodule

bind per_state_dominance_table psdt_checker u_psdt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.mode      (mode),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.dominated (dominated)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dominance table testbench
// Drives check, expand and new-round requests through every order mode and
// several budget settings, with random gaps on the request side and random
// stalls on the result side. Each dominated flag is compared with a typed-in
// value or a local model of the per-state records, scores and Pareto fronts.
// ----------------------------------------------------------------------------
module testbench;

	localparam int NSTATES   = 1024;
	localparam int FRONT_MAX = 64;
	localparam int LIMIT     = 3000000;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [1:0] FROM_MODEL = 2'd2;

	typedef struct packed {
		logic [1:0]  md;
		logic [9:0]  idx;
		logic [31:0] c1;
		logic [31:0] c2;
		logic [31:0] h1;
		logic [31:0] h2;
		logic [1:0]  flag;
	} req_row_t;

	typedef struct packed {
		logic [2:0]  ord;
		logic [31:0] b1;
		logic [31:0] b2;
		logic [15:0] n;
	} setting_t;

	localparam req_row_t DIRECTED [19] = '{
		'{psdt_pkg::MODE_CHECK,  10'd5, 32'd0, 32'd0,   32'd0, 32'd0, 2'd0},
		'{psdt_pkg::MODE_EXPAND, 10'd5, 32'd0, 32'd10,  32'd0, 32'd0, 2'd0},
		'{psdt_pkg::MODE_CHECK,  10'd5, 32'd0, 32'd10,  32'd0, 32'd0, 2'd0},
		'{psdt_pkg::MODE_ROUND,  10'd0, 32'd0, 32'd0,   32'd0, 32'd0, 2'd0},
		'{psdt_pkg::MODE_EXPAND, 10'd5, 32'd3, 32'd100, 32'd0, 32'd0, 2'd0},
		'{psdt_pkg::MODE_CHECK,  10'd5, 32'd3, 32'd100, 32'd0, 32'd0, 2'd1},
		'{psdt_pkg::MODE_CHECK,  10'd5, 32'd3, 32'd99,  32'd0, 32'd0, 2'd0},
		'{MODE_SPARE,            10'd5, 32'd0, 32'd200, 32'd0, 32'd0, 2'd1},
		'{psdt_pkg::MODE_EXPAND, 10'd1023, psdt_pkg::ONES32, psdt_pkg::ONES32,
			psdt_pkg::ONES32, psdt_pkg::ONES32, 2'd0},
		'{psdt_pkg::MODE_CHECK,  10'd1023, psdt_pkg::ONES32, psdt_pkg::ONES32,
			psdt_pkg::ONES32, psdt_pkg::ONES32, 2'd1},
		'{psdt_pkg::MODE_CHECK,  10'd0, psdt_pkg::ONES32, psdt_pkg::ONES32,
			32'd0, 32'd0, 2'd0},
		'{psdt_pkg::MODE_EXPAND, 10'd0, 32'd0, 32'd0,   32'd0, 32'd0, 2'd0},
		'{psdt_pkg::MODE_CHECK,  10'd0, 32'd0, 32'd0,   32'd0, 32'd0, 2'd1},
		'{psdt_pkg::MODE_EXPAND, 10'd5, 32'd7, 32'd50,  32'd1, 32'd1, FROM_MODEL},
		'{psdt_pkg::MODE_CHECK,  10'd5, 32'd7, 32'd60,  32'd1, 32'd1, FROM_MODEL},
		'{psdt_pkg::MODE_ROUND,  10'd1023, psdt_pkg::ONES32, psdt_pkg::ONES32,
			psdt_pkg::ONES32, psdt_pkg::ONES32, 2'd0},
		'{psdt_pkg::MODE_CHECK,  10'd5, 32'd0, 32'd0,   32'd0, 32'd0, 2'd0},
		'{psdt_pkg::MODE_EXPAND, 10'd682, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555,
			32'hAAAA_AAAA, 2'd0},
		'{psdt_pkg::MODE_CHECK,  10'd682, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555, 2'd1}
	};

	localparam setting_t PHASES [11] = '{
		'{psdt_pkg::ORD_LEX1,   32'd1,     32'd1,  16'd50},
		'{psdt_pkg::ORD_LEX2,   32'd5,     32'd9,  16'd50},
		'{psdt_pkg::ORD_SCORE,  32'd0,     32'd0,  16'd35},
		'{psdt_pkg::ORD_SCORE,  psdt_pkg::ONES32, psdt_pkg::ONES32, 16'd25},
		'{psdt_pkg::ORD_SKEW,   32'd1000,  32'd7,  16'd35},
		'{psdt_pkg::ORD_SKEW,   psdt_pkg::ONES32, 32'd0,  16'd25},
		'{psdt_pkg::ORD_SCORE,  32'd65536, 32'd3,  16'd30},
		'{psdt_pkg::ORD_PARETO, 32'd1,     32'd1,  16'd130},
		'{3'd7,                 32'd1,     32'd1,  16'd30},
		'{3'd5,                 32'd1,     32'd1,  16'd20},
		'{psdt_pkg::ORD_LEX1,   32'd1,     32'd1,  16'd20}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  mode;
	logic [9:0]  state_index;
	logic [31:0] cost_first;
	logic [31:0] cost_second;
	logic [31:0] heur_first;
	logic [31:0] heur_second;
	logic        out_valid;
	logic        out_stall;
	logic        dominated;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	per_state_dominance_table DUT (.*);

	// local copy of the table
	logic [2:0]  ord_mode;
	logic [31:0] bud1;
	logic [31:0] bud2;
	logic [31:0] round_ctr;
	logic [31:0] stamp [NSTATES];
	logic [31:0] min_second [NSTATES];
	logic [31:0] min_first [NSTATES];
	logic [31:0] min_score [NSTATES];
	int          front_len [NSTATES];
	logic [31:0] front_g1 [NSTATES][FRONT_MAX];
	logic [31:0] front_g2 [NSTATES][FRONT_MAX];

	bit dominated_q [$];
	int errors;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic report(input string what);
		errors++;
		$display("[%0t] error: %s", $realtime, what);
	endtask

	function automatic bit path_score(input logic [31:0] g1, g2, h1, h2,
			output logic [31:0] s);
		logic [65:0] b1, b2, f1, f2, t1, t2, d, num, q;
		b1 = (bud1 == 0) ? 66'd1 : {34'd0, bud1};
		b2 = (bud2 == 0) ? 66'd1 : {34'd0, bud2};
		t1 = (({34'd0, g1} + {34'd0, h1}) << 16) / b1;
		t2 = (({34'd0, g2} + {34'd0, h2}) << 16) / b2;
		f1 = (t1 > {34'd0, psdt_pkg::ONES32}) ? {34'd0, psdt_pkg::ONES32} : t1;
		f2 = (t2 > {34'd0, psdt_pkg::ONES32}) ? {34'd0, psdt_pkg::ONES32} : t2;
		if (ord_mode == psdt_pkg::ORD_SKEW) begin
			t1 = f1 * b2 / (b1 + b2);
			t2 = f2 * b1 / (b1 + b2);
			f1 = t1;
			f2 = t2;
		end
		d = f1 + f2;
		s = '0;
		if (d == 0)
			return 1'b0;
		num = f1 * f1 + f2 * f2;
		q = num / d;
		s = (q > {34'd0, psdt_pkg::ONES32}) ? psdt_pkg::ONES32 : q[31:0];
		return 1'b1;
	endfunction

	function automatic bit predict_dominated(input logic [1:0] md, input logic [9:0] idx,
			input logic [31:0] g1, g2, h1, h2);
		bit live, dom, ok;
		logic [31:0] s;
		int w;
		if (md == psdt_pkg::MODE_ROUND) begin
			round_ctr = (round_ctr == psdt_pkg::ONES32) ? 32'd1 : round_ctr + 32'd1;
			return 1'b0;
		end
		live = (round_ctr != 0) && (stamp[idx] == round_ctr);
		dom = 1'b0;
		ok = path_score(g1, g2, h1, h2, s);
		if (live) begin
			case (ord_mode)
				psdt_pkg::ORD_LEX1: dom = (g2 >= min_second[idx]);
				psdt_pkg::ORD_LEX2: dom = (g1 >= min_first[idx]);
				psdt_pkg::ORD_SCORE, psdt_pkg::ORD_SKEW: dom = ok && (s >= min_score[idx]);
				default: begin
					for (int i = 0; i < front_len[idx]; i++)
						if (front_g1[idx][i] <= g1 && front_g2[idx][i] <= g2)
							dom = 1'b1;
				end
			endcase
		end
		if (md != psdt_pkg::MODE_EXPAND || dom)
			return dom;
		if (!live) begin
			stamp[idx] = round_ctr;
			min_second[idx] = psdt_pkg::ONES32;
			min_first[idx] = psdt_pkg::ONES32;
			min_score[idx] = psdt_pkg::ONES32;
			front_len[idx] = 0;
		end
		case (ord_mode)
			psdt_pkg::ORD_LEX1: if (g2 < min_second[idx]) min_second[idx] = g2;
			psdt_pkg::ORD_LEX2: if (g1 < min_first[idx]) min_first[idx] = g1;
			psdt_pkg::ORD_SCORE, psdt_pkg::ORD_SKEW:
				if (ok && s < min_score[idx]) min_score[idx] = s;
			default: begin
				w = 0;
				for (int i = 0; i < front_len[idx]; i++) begin
					if (!(front_g1[idx][i] >= g1 && front_g2[idx][i] >= g2)) begin
						front_g1[idx][w] = front_g1[idx][i];
						front_g2[idx][w] = front_g2[idx][i];
						w++;
					end
				end
				if (w < FRONT_MAX) begin
					front_g1[idx][w] = g1;
					front_g2[idx][w] = g2;
					w++;
				end
				front_len[idx] = w;
			end
		endcase
		return 1'b0;
	endfunction

	task automatic wait_drained();
		while (dominated_q.size() > 0)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] regnum, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {regnum, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (regnum)
			psdt_pkg::REG_ORDER:   ord_mode = value[2:0];
			psdt_pkg::REG_BUDGET1: bud1 = value;
			default:               bud2 = value;
		endcase
	endtask

	// flag: 0 or 1 typed in, FROM_MODEL takes the local model's answer
	task automatic send_request(input logic [1:0] md, input logic [9:0] idx,
			input logic [31:0] c1, c2, h1, h2, input logic [1:0] flag, input bit burst);
		int gap;
		bit dom;
		gap = burst ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= md;
		state_index <= idx;
		cost_first  <= c1;
		cost_second <= c2;
		heur_first  <= h1;
		heur_second <= h2;
		do @(posedge clk); while (in_stall);
		dom = predict_dominated(md, idx, c1, c2, h1, h2);
		dominated_q.push_back((flag == FROM_MODEL) ? dom : flag[0]);
	endtask

	function automatic logic [31:0] draw_cost();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return psdt_pkg::ONES32;
			2: return $urandom;
			default: return $urandom_range(0, 2000);
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (dominated_q.size() == 0)
				report("transfer with no expected result");
			else if (dominated !== dominated_q.pop_front())
				report($sformatf("dominated flag wrong, got %b", dominated));
		end
	end

	initial begin
		int w;
		out_stall = 1'b1;
		forever begin
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	initial begin
		logic [1:0]  md;
		logic [9:0]  idx;
		logic [31:0] c1, c2;
		bit          burst;
		int          pick;
		cycles = 0;
		errors = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = psdt_pkg::MODE_CHECK;
		state_index = '0;
		cost_first = '0;
		cost_second = '0;
		heur_first = '0;
		heur_second = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		ord_mode = psdt_pkg::ORD_LEX1;
		bud1 = 32'd1;
		bud2 = 32'd1;
		round_ctr = '0;
		for (int i = 0; i < NSTATES; i++) begin
			stamp[i] = '0;
			front_len[i] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i])
			send_request(DIRECTED[i].md, DIRECTED[i].idx, DIRECTED[i].c1, DIRECTED[i].c2,
				DIRECTED[i].h1, DIRECTED[i].h2, DIRECTED[i].flag, 1'b0);

		foreach (PHASES[p]) begin
			in_valid <= 1'b0;
			wait_drained();
			apb_write(psdt_pkg::REG_ORDER, {29'd0, PHASES[p].ord});
			apb_write(psdt_pkg::REG_BUDGET1, PHASES[p].b1);
			apb_write(psdt_pkg::REG_BUDGET2, PHASES[p].b2);
			burst = 1'b0;
			for (int k = 0; k < PHASES[p].n; k++) begin
				if (k % 16 == 0)
					burst = ($urandom_range(0, 3) == 0);
				pick = $urandom_range(0, 99);
				if (PHASES[p].ord >= psdt_pkg::ORD_PARETO) begin
					md = (pick < 2) ? psdt_pkg::MODE_ROUND :
						(pick < 75) ? psdt_pkg::MODE_EXPAND :
						(pick < 78) ? MODE_SPARE : psdt_pkg::MODE_CHECK;
					idx = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 1));
					c1 = $urandom_range(0, 1000);
					c2 = 32'd1000 - c1 + $urandom_range(0, 2);
					if ($urandom_range(0, 9) == 0) begin
						c1 = draw_cost();
						c2 = draw_cost();
					end
				end else begin
					md = (pick < 6) ? psdt_pkg::MODE_ROUND :
						(pick < 56) ? psdt_pkg::MODE_EXPAND :
						(pick < 60) ? MODE_SPARE : psdt_pkg::MODE_CHECK;
					idx = ($urandom_range(0, 6) == 0) ? 10'($urandom) : 10'($urandom_range(0, 7));
					c1 = draw_cost();
					c2 = draw_cost();
				end
				send_request(md, idx, c1, c2, draw_cost(), draw_cost(), FROM_MODEL, burst);
			end
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
